// ----- rtl/core/bgsab_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsab_pkg: shared types and constants of the glyph sampler and blender
// Holds the store geometry, configuration register codes, the pipeline
// latency and the stage records that travel between the pipeline modules.
// ----------------------------------------------------------------------------
package bgsab_pkg;

  // Largest glyph side in texels; default of the top-level parameter.
  localparam int MAX_GLYPH_SIDE = 64;

  // Glyph store geometry: addresses wrap to 12 bits.
  localparam int ADDR_W      = 12;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int SIDE_CFG_W = 7;
  localparam int COLOR_W    = 24;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_WIDTH  = 2'd0,
    CFG_GLYPH_HEIGHT = 2'd1,
    CFG_TEXT_COLOR   = 2'd2
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [SIDE_CFG_W-1:0] GLYPH_SIDE_RST = 7'd1;
  localparam logic [COLOR_W-1:0]    TEXT_COLOR_RST = 24'hFFFFFF;

  // Cycles from an accepted word to its result strobe.
  localparam int PIPE_LATENCY = 6;

  // Opaque alpha byte of a written pixel.
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Texel fetch request: four row-major store addresses plus sideband.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr00;
    logic [ADDR_W-1:0] addr01;
    logic [ADDR_W-1:0] addr10;
    logic [ADDR_W-1:0] addr11;
    logic [7:0]        frac_x;
    logic [7:0]        frac_y;
    logic [31:0]       dest;
  } fetch_t;

  // Four neighbor texels read from the store plus sideband.
  typedef struct packed {
    logic        valid;
    logic [7:0]  tex00;
    logic [7:0]  tex01;
    logic [7:0]  tex10;
    logic [7:0]  tex11;
    logic [7:0]  frac_x;
    logic [7:0]  frac_y;
    logic [31:0] dest;
  } texels_t;

  // Sampled coverage handed to the blender.
  typedef struct packed {
    logic        valid;
    logic [7:0]  cov;
    logic [31:0] dest;
  } cov_t;

endpackage

// ----- rtl/core/bgsab_addr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsab_addr: coordinate split, neighbor clamp and store address stages
// Stage one splits the 8.8 coordinates and clamps the four neighbors to
// the tile; stage two forms the row-major addresses, wrapped to 12 bits.
// ----------------------------------------------------------------------------
module bgsab_addr #(
  parameter int MAX_GLYPH_SIDE = bgsab_pkg::MAX_GLYPH_SIDE
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            blend_acc,
  input  logic [15:0]                     sample_x,
  input  logic [15:0]                     sample_y,
  input  logic [31:0]                     dest_pixel,
  input  logic [bgsab_pkg::SIDE_CFG_W-1:0] glyph_width,
  input  logic [bgsab_pkg::SIDE_CFG_W-1:0] glyph_height,
  output bgsab_pkg::fetch_t               fetch
);

  localparam int SIDE_W = $clog2(MAX_GLYPH_SIDE + 1);
  localparam int IDX_W  = $clog2(MAX_GLYPH_SIDE);
  localparam int PROD_W = IDX_W + SIDE_W + 1;
  localparam int SUM_W  = (PROD_W > bgsab_pkg::ADDR_W) ? PROD_W : bgsab_pkg::ADDR_W;

  // Saturate a configured side to 1..MAX_GLYPH_SIDE.
  function automatic logic [SIDE_W-1:0] eff_side(input logic [bgsab_pkg::SIDE_CFG_W-1:0] v);
    logic [SIDE_W-1:0] s;
    if (v == '0) begin
      s = SIDE_W'(1);
    end else if (32'(v) > MAX_GLYPH_SIDE) begin
      s = SIDE_W'(MAX_GLYPH_SIDE);
    end else begin
      s = SIDE_W'(v);
    end
    return s;
  endfunction

  // Clamp a neighbor index to side - 1.
  function automatic logic [IDX_W-1:0] clamp_idx(input logic [8:0] v,
                                                 input logic [SIDE_W-1:0] side);
    logic [IDX_W-1:0] r;
    if (32'(v) >= 32'(side)) begin
      r = IDX_W'(32'(side) - 1);
    end else begin
      r = IDX_W'(v);
    end
    return r;
  endfunction

  // Row-major address, wrapped to the store size.
  function automatic logic [bgsab_pkg::ADDR_W-1:0] row_addr(input logic [IDX_W-1:0] y,
                                                           input logic [IDX_W-1:0] x,
                                                           input logic [SIDE_W-1:0] w);
    logic [SUM_W-1:0] s;
    s = SUM_W'(y) * SUM_W'(w) + SUM_W'(x);
    return s[bgsab_pkg::ADDR_W-1:0];
  endfunction

  logic [SIDE_W-1:0] side_w;
  logic [SIDE_W-1:0] side_h;
  logic [7:0]        ip_x;
  logic [7:0]        ip_y;
  logic [7:0]        fr_x;
  logic [7:0]        fr_y;

  logic              s1_valid_r;
  logic [IDX_W-1:0]  x0_r;
  logic [IDX_W-1:0]  x1_r;
  logic [IDX_W-1:0]  y0_r;
  logic [IDX_W-1:0]  y1_r;
  logic [7:0]        s1_fx_r;
  logic [7:0]        s1_fy_r;
  logic [31:0]       s1_dest_r;

  bgsab_pkg::fetch_t fetch_r;
  bgsab_pkg::fetch_t fetch_nxt;

  assign side_w = eff_side(glyph_width);
  assign side_h = eff_side(glyph_height);

  // A negative coordinate samples texel 0 with zero fraction.
  always_comb begin
    if (sample_x[15]) begin
      ip_x = 8'd0;
      fr_x = 8'd0;
    end else begin
      ip_x = sample_x[15:8];
      fr_x = sample_x[7:0];
    end
    if (sample_y[15]) begin
      ip_y = 8'd0;
      fr_y = 8'd0;
    end else begin
      ip_y = sample_y[15:8];
      fr_y = sample_y[7:0];
    end
  end

  // Stage one: clamped neighbor indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= blend_acc;
    end
    x0_r      <= clamp_idx({1'b0, ip_x}, side_w);
    x1_r      <= clamp_idx({1'b0, ip_x} + 9'd1, side_w);
    y0_r      <= clamp_idx({1'b0, ip_y}, side_h);
    y1_r      <= clamp_idx({1'b0, ip_y} + 9'd1, side_h);
    s1_fx_r   <= fr_x;
    s1_fy_r   <= fr_y;
    s1_dest_r <= dest_pixel;
  end

  // Stage two: the four store addresses.
  always_comb begin
    fetch_nxt.valid  = s1_valid_r;
    fetch_nxt.addr00 = row_addr(y0_r, x0_r, side_w);
    fetch_nxt.addr01 = row_addr(y0_r, x1_r, side_w);
    fetch_nxt.addr10 = row_addr(y1_r, x0_r, side_w);
    fetch_nxt.addr11 = row_addr(y1_r, x1_r, side_w);
    fetch_nxt.frac_x = s1_fx_r;
    fetch_nxt.frac_y = s1_fy_r;
    fetch_nxt.dest   = s1_dest_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetch_r.valid <= 1'b0;
    end else begin
      fetch_r.valid <= fetch_nxt.valid;
    end
    fetch_r.addr00 <= fetch_nxt.addr00;
    fetch_r.addr01 <= fetch_nxt.addr01;
    fetch_r.addr10 <= fetch_nxt.addr10;
    fetch_r.addr11 <= fetch_nxt.addr11;
    fetch_r.frac_x <= fetch_nxt.frac_x;
    fetch_r.frac_y <= fetch_nxt.frac_y;
    fetch_r.dest   <= fetch_nxt.dest;
  end

  assign fetch = fetch_r;

endmodule

// ----- rtl/core/bgsab_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsab_store: glyph coverage store
// Two identical copies of the 4096 x 8 store, each written on every load
// and each read at two addresses, give the four neighbor texels per cycle.
// A load is registered before it reaches the store.
// ----------------------------------------------------------------------------
module bgsab_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [bgsab_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [7:0]                    wr_data,
  input  bgsab_pkg::fetch_t             fetch,
  output bgsab_pkg::texels_t            texels
);

  logic [7:0] mem_top [bgsab_pkg::STORE_DEPTH];
  logic [7:0] mem_bot [bgsab_pkg::STORE_DEPTH];

  logic                         wr_en_r;
  logic [bgsab_pkg::ADDR_W-1:0] wr_addr_r;
  logic [7:0]                   wr_data_r;

  bgsab_pkg::texels_t texels_r;

  // Register each load before it is written. A blend word taken just before the
  // load reads the store at the same edge that writes the load, so it still sees
  // the old texel, while a blend word taken right after the load sees the new one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_en_r <= 1'b0;
    end else begin
      wr_en_r <= wr_en;
    end
    wr_addr_r <= wr_addr;
    wr_data_r <= wr_data;
  end

  // Both copies take the same load.
  always_ff @(posedge clk) begin
    if (wr_en_r) begin
      mem_top[wr_addr_r] <= wr_data_r;
      mem_bot[wr_addr_r] <= wr_data_r;
    end
  end

  // Registered reads: the top copy serves the upper row, the bottom copy the lower.
  always_ff @(posedge clk) begin
    texels_r.tex00 <= mem_top[fetch.addr00];
    texels_r.tex01 <= mem_top[fetch.addr01];
    texels_r.tex10 <= mem_bot[fetch.addr10];
    texels_r.tex11 <= mem_bot[fetch.addr11];
  end

  // Sideband follows the read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      texels_r.valid <= 1'b0;
    end else begin
      texels_r.valid <= fetch.valid;
    end
    texels_r.frac_x <= fetch.frac_x;
    texels_r.frac_y <= fetch.frac_y;
    texels_r.dest   <= fetch.dest;
  end

  assign texels = texels_r;

endmodule

// ----- rtl/core/bgsab_interp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsab_interp: bilinear interpolation stages
// Stage one lerps the upper and lower texel pairs horizontally; stage two
// lerps those two results vertically into the coverage value.
// ----------------------------------------------------------------------------
module bgsab_interp (
  input  logic               clk,
  input  logic               rst_n,
  input  bgsab_pkg::texels_t texels,
  output bgsab_pkg::cov_t    cov
);

  // lo + floor((hi - lo) * t / 256), kept to 8 bits.
  function automatic logic [7:0] lerp8(input logic [7:0] lo, input logic [7:0] hi,
                                       input logic [7:0] t);
    logic signed [8:0]  d;
    logic signed [17:0] p;
    logic signed [17:0] q;
    d = $signed({1'b0, hi}) - $signed({1'b0, lo});
    p = 18'(d) * $signed({10'd0, t});
    q = p >>> 8;
    return lo + q[7:0];
  endfunction

  logic              h_valid_r;
  logic [7:0]        top_r;
  logic [7:0]        bot_r;
  logic [7:0]        h_fy_r;
  logic [31:0]       h_dest_r;

  bgsab_pkg::cov_t   cov_r;

  // Horizontal pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_valid_r <= 1'b0;
    end else begin
      h_valid_r <= texels.valid;
    end
    top_r    <= lerp8(texels.tex00, texels.tex01, texels.frac_x);
    bot_r    <= lerp8(texels.tex10, texels.tex11, texels.frac_x);
    h_fy_r   <= texels.frac_y;
    h_dest_r <= texels.dest;
  end

  // Vertical pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cov_r.valid <= 1'b0;
    end else begin
      cov_r.valid <= h_valid_r;
    end
    cov_r.cov  <= lerp8(top_r, bot_r, h_fy_r);
    cov_r.dest <= h_dest_r;
  end

  assign cov = cov_r;

endmodule

// ----- rtl/core/bgsab_blend.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsab_blend: per-channel alpha blend and result register
// Stage one forms c*a + d*(255-a) for each color channel; stage two divides
// by 255 with an add-and-shift and registers the result word.
// ----------------------------------------------------------------------------
module bgsab_blend (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bgsab_pkg::cov_t               cov,
  input  logic [bgsab_pkg::COLOR_W-1:0] text_color,
  output logic                          out_strobe,
  output logic [31:0]                   out_blended_pixel,
  output logic [7:0]                    out_coverage,
  output logic                          out_pixel_written
);

  // Weighted sum of one channel; at most 255 * 255.
  function automatic logic [16:0] mix(input logic [7:0] c, input logic [7:0] d,
                                      input logic [7:0] a);
    logic [15:0] pc;
    logic [15:0] pd;
    pc = 16'(c) * 16'(a);
    pd = 16'(d) * 16'(8'd255 - a);
    return 17'(pc) + 17'(pd);
  endfunction

  // Exact x / 255 for x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [16:0] t;
    t = x + 17'd1 + (x >> 8);
    return t[15:8];
  endfunction

  logic        m_valid_r;
  logic [16:0] sum_r_r;
  logic [16:0] sum_g_r;
  logic [16:0] sum_b_r;
  logic [7:0]  m_cov_r;
  logic [31:0] m_dest_r;

  logic        strobe_r;
  logic [31:0] pixel_r;
  logic [31:0] pixel_nxt;
  logic [7:0]  cov_out_r;
  logic        written_r;

  // Channel products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= cov.valid;
    end
    sum_r_r  <= mix(text_color[23:16], cov.dest[23:16], cov.cov);
    sum_g_r  <= mix(text_color[15:8], cov.dest[15:8], cov.cov);
    sum_b_r  <= mix(text_color[7:0], cov.dest[7:0], cov.cov);
    m_cov_r  <= cov.cov;
    m_dest_r <= cov.dest;
  end

  // Zero coverage leaves the pixel as it was.
  always_comb begin
    if (m_cov_r == 8'd0) begin
      pixel_nxt = m_dest_r;
    end else begin
      pixel_nxt = {bgsab_pkg::ALPHA_OPAQUE, div255(sum_r_r), div255(sum_g_r),
                   div255(sum_b_r)};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= m_valid_r;
    end
    pixel_r   <= pixel_nxt;
    cov_out_r <= m_cov_r;
    written_r <= (m_cov_r != 8'd0);
  end

  assign out_strobe        = strobe_r;
  assign out_blended_pixel = pixel_r;
  assign out_coverage      = cov_out_r;
  assign out_pixel_written = written_r;

endmodule

// ----- rtl/core/bilinear_glyph_sample_alpha_blend.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_glyph_sample_alpha_blend: glyph tile sampler with alpha blend
// Holds one 8-bit coverage tile, samples it bilinearly at an 8.8 coordinate
// and blends the text color over a destination pixel.
// ----------------------------------------------------------------------------
// Usage:
//   An input word is taken at every rising edge with start high and busy
//   low; busy is never raised, so a word can be given in every cycle.
//   in_mode low loads in_texel_value at in_texel_index into the tile and
//   gives no result. in_mode high samples at in_sample_x / in_sample_y and
//   blends over in_dest_pixel.
//   Each blend word gives one result word, shown for exactly one cycle with
//   out_strobe high. Results leave in the order their words came in.
//   Throughput is one word per cycle; a blend word passes two address
//   stages, the registered store read, two interpolation stages and the
//   blend multiply, with the divide by 255 ahead of the output register.
//   Four texels come from two copies of the store, each read at two ports.
//   The configuration port takes glyph_width, glyph_height and text_color;
//   the user writes them only while no blend word is in flight (unchecked).
//   Reset clears the pipeline valid bits and sets width 1, height 1 and
//   white text; the tile contents are undefined until loaded.
//   The receiver cannot stall: a result must be taken in its strobe cycle.
// ----------------------------------------------------------------------------
module bilinear_glyph_sample_alpha_blend #(
  parameter int MAX_GLYPH_SIDE = bgsab_pkg::MAX_GLYPH_SIDE
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_mode,
  input  logic [11:0]                      in_texel_index,
  input  logic [7:0]                       in_texel_value,
  input  logic signed [15:0]               in_sample_x,
  input  logic signed [15:0]               in_sample_y,
  input  logic [31:0]                      in_dest_pixel,
  // Result channel
  output logic                             out_strobe,
  output logic [31:0]                      out_blended_pixel,
  output logic [7:0]                       out_coverage,
  output logic                             out_pixel_written,
  // Configuration port
  input  logic                             cfg_we,
  input  logic [bgsab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bgsab_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [bgsab_pkg::SIDE_CFG_W-1:0]    width_r;
  logic [bgsab_pkg::SIDE_CFG_W-1:0]    height_r;
  logic [bgsab_pkg::COLOR_W-1:0]       text_color_r;
  logic                                accept;
  logic                                load_acc;
  logic                                blend_acc;

  bgsab_pkg::fetch_t                   fetch;
  bgsab_pkg::texels_t                  texels;
  bgsab_pkg::cov_t                     cov;

  // Every cycle can take a word.
  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign load_acc  = accept && !in_mode;
  assign blend_acc = accept && in_mode;

  // Configuration registers; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= bgsab_pkg::GLYPH_SIDE_RST;
      height_r     <= bgsab_pkg::GLYPH_SIDE_RST;
      text_color_r <= bgsab_pkg::TEXT_COLOR_RST;
    end else if (cfg_we) begin
      case (bgsab_pkg::cfg_reg_t'(cfg_index))
        bgsab_pkg::CFG_GLYPH_WIDTH: begin
          width_r <= cfg_wdata[bgsab_pkg::SIDE_CFG_W-1:0];
        end
        bgsab_pkg::CFG_GLYPH_HEIGHT: begin
          height_r <= cfg_wdata[bgsab_pkg::SIDE_CFG_W-1:0];
        end
        bgsab_pkg::CFG_TEXT_COLOR: begin
          text_color_r <= cfg_wdata[bgsab_pkg::COLOR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Address stages.
  bgsab_addr #(
    .MAX_GLYPH_SIDE (MAX_GLYPH_SIDE)
  ) u_addr (
    .clk          (clk),
    .rst_n        (rst_n),
    .blend_acc    (blend_acc),
    .sample_x     (in_sample_x),
    .sample_y     (in_sample_y),
    .dest_pixel   (in_dest_pixel),
    .glyph_width  (width_r),
    .glyph_height (height_r),
    .fetch        (fetch)
  );

  // Tile store: a load is registered before it lands in the store.
  bgsab_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (load_acc),
    .wr_addr (in_texel_index),
    .wr_data (in_texel_value),
    .fetch   (fetch),
    .texels  (texels)
  );

  // Bilinear interpolation.
  bgsab_interp u_interp (
    .clk    (clk),
    .rst_n  (rst_n),
    .texels (texels),
    .cov    (cov)
  );

  // Blend and result register.
  bgsab_blend u_blend (
    .clk               (clk),
    .rst_n             (rst_n),
    .cov               (cov),
    .text_color        (text_color_r),
    .out_strobe        (out_strobe),
    .out_blended_pixel (out_blended_pixel),
    .out_coverage      (out_coverage),
    .out_pixel_written (out_pixel_written)
  );

endmodule

// ----- rtl/core/bgsab_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsab_checker: port-level checks of the glyph sampler
// Watches the top-level ports for latency, silent loads, a quiet reset and
// the rules that tie the result fields together.
// ----------------------------------------------------------------------------
module bgsab_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_mode,
  input logic        out_strobe,
  input logic [31:0] out_blended_pixel,
  input logic [7:0]  out_coverage,
  input logic        out_pixel_written
);

  // A blend word gives its result after the fixed latency; the strobe rises
  // at that edge and is seen high at the edge after it.
  a_blend_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode) |-> ##(bgsab_pkg::PIPE_LATENCY + 1) out_strobe)
    else $error("blend word produced no result at the expected latency");

  // A load word never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_mode) |-> ##(bgsab_pkg::PIPE_LATENCY + 1) !out_strobe)
    else $error("load word produced a result");

  // The written flag follows the coverage.
  a_written_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_pixel_written == (out_coverage != 8'd0)))
    else $error("pixel_written disagrees with coverage");

  // A written pixel is opaque.
  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_pixel_written) |->
      (out_blended_pixel[31:24] == bgsab_pkg::ALPHA_OPAQUE))
    else $error("written pixel is not opaque");

  // Nothing comes out in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

endmodule

bind bilinear_glyph_sample_alpha_blend bgsab_checker u_bgsab_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_mode           (in_mode),
  .out_strobe        (out_strobe),
  .out_blended_pixel (out_blended_pixel),
  .out_coverage      (out_coverage),
  .out_pixel_written (out_pixel_written)
);
